### src/qte_pkg.sv
`default_nettype none
package qte_pkg;

   // number of micro-rotations in each angle unit
   localparam int CORDIC_STAGES = 16;

   // datapath widths
   localparam int CW = 36;             // cordic x and y
   localparam int ZW = 24;             // angle accumulator, Q20
   localparam int SQRT_STAGES = 16;    // one result bit per stage

   // angle constants in Q20
   localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
   localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;

   // round(atan(2^-i) * 2^20)
   localparam logic signed [ZW-1:0] ATAN_Q20 [24] = '{
      24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
      24'sd65451, 24'sd32757, 24'sd16383, 24'sd8192,
      24'sd4096, 24'sd2048, 24'sd1024, 24'sd512,
      24'sd256, 24'sd128, 24'sd64, 24'sd32,
      24'sd16, 24'sd8, 24'sd4, 24'sd2,
      24'sd1, 24'sd0, 24'sd0, 24'sd0
   };

   // gravity and yaw operands carried alongside the root
   typedef struct packed {
      logic signed [15:0]   gx;
      logic signed [15:0]   gy;
      logic signed [15:0]   gz;
      logic signed [CW-1:0] ya;
      logic signed [CW-1:0] yb;
   } payload_type;

endpackage
`default_nettype wire

### src/qte_front.sv
`default_nettype none
module qte_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [15:0] quat_w,
   input  wire logic signed [15:0] quat_x,
   input  wire logic signed [15:0] quat_y,
   input  wire logic signed [15:0] quat_z,
   output logic                    out_valid,
   output logic [31:0]             out_sum,
   output qte_pkg::payload_type    out_pay
);
   logic [3:0] valid_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xz_ff, wy_ff, wx_ff, yz_ff, xy_ff, wz_ff;
   qte_pkg::payload_type pay2_ff, pay3_ff, pay4_ff;
   qte_pkg::payload_type pay2_in;
   logic signed [31:0] sqy_ff, sqz_ff;
   logic [31:0] sum_ff;
   logic signed [34:0] gx28, gy28, gz28;

   // round half up to Q2.14 and saturate
   function automatic logic signed [15:0] round_sat(input logic signed [34:0] v);
      logic signed [34:0] r;
      r = (v + 35'sd8192) >>> 14;
      if (r > 35'sd32767)
         return 16'sh7fff;
      else if (r < -35'sd32768)
         return 16'sh8000;
      else
         return r[15:0];
   endfunction

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= {valid_ff[2:0], in_valid};
   end

   // stage 1: quaternion products
   always_ff @(posedge clock) begin
      ww_ff <= quat_w * quat_w;
      xx_ff <= quat_x * quat_x;
      yy_ff <= quat_y * quat_y;
      zz_ff <= quat_z * quat_z;
      xz_ff <= quat_x * quat_z;
      wy_ff <= quat_w * quat_y;
      wx_ff <= quat_w * quat_x;
      yz_ff <= quat_y * quat_z;
      xy_ff <= quat_x * quat_y;
      wz_ff <= quat_w * quat_z;
   end

   // stage 2: gravity vector and yaw operands
   always_comb begin
      gx28 = (35'(xz_ff) - 35'(wy_ff)) <<< 1;
      gy28 = (35'(wx_ff) + 35'(yz_ff)) <<< 1;
      gz28 = 35'(ww_ff) - 35'(xx_ff) - 35'(yy_ff) + 35'(zz_ff);
      pay2_in.gx = round_sat(gx28);
      pay2_in.gy = round_sat(gy28);
      pay2_in.gz = round_sat(gz28);
      pay2_in.ya = (36'(xy_ff) - 36'(wz_ff)) <<< 1;
      pay2_in.yb = (36'(ww_ff) <<< 1) + (36'(xx_ff) <<< 1) - 36'sd268435456;
   end

   always_ff @(posedge clock) begin
      pay2_ff <= pay2_in;
      // stage 3: squares for the magnitude
      sqy_ff  <= pay2_ff.gy * pay2_ff.gy;
      sqz_ff  <= pay2_ff.gz * pay2_ff.gz;
      pay3_ff <= pay2_ff;
      // stage 4: sum of squares
      sum_ff  <= 32'(sqy_ff) + 32'(sqz_ff);
      pay4_ff <= pay3_ff;
   end

   assign out_valid = valid_ff[3];
   assign out_sum   = sum_ff;
   assign out_pay   = pay4_ff;
endmodule
`default_nettype wire

### src/qte_sqrt.sv
`default_nettype none
module qte_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [31:0]           in_sum,
   input  wire qte_pkg::payload_type  in_pay,
   output logic                       out_valid,
   output logic [15:0]                out_root,
   output qte_pkg::payload_type       out_pay
);
   localparam int N = qte_pkg::SQRT_STAGES;

   logic [N-1:0]         valid_ff;
   logic [32:0]          rem_ff  [N];
   logic [32:0]          root_ff [N];
   qte_pkg::payload_type pay_ff  [N];
   logic [N-1:0]         valid_stg;
   logic [32:0]          rem_stg  [N];
   logic [32:0]          root_stg [N];
   qte_pkg::payload_type pay_stg  [N];

   // stage inputs
   always_comb begin
      valid_stg[0] = in_valid;
      rem_stg[0]   = 33'(in_sum);
      root_stg[0]  = '0;
      pay_stg[0]   = in_pay;
      for (int k = 1; k < N; k++) begin
         valid_stg[k] = valid_ff[k-1];
         rem_stg[k]   = rem_ff[k-1];
         root_stg[k]  = root_ff[k-1];
         pay_stg[k]   = pay_ff[k-1];
      end
   end

   // one result bit per stage, restoring square root
   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [32:0] BIT = 33'd1 << (30 - 2 * k);
      always_ff @(posedge clock) begin
         if (reset)
            valid_ff[k] <= 1'b0;
         else
            valid_ff[k] <= valid_stg[k];
      end
      always_ff @(posedge clock) begin
         if (rem_stg[k] >= root_stg[k] + BIT) begin
            rem_ff[k]  <= rem_stg[k] - (root_stg[k] + BIT);
            root_ff[k] <= (root_stg[k] >> 1) + BIT;
         end else begin
            rem_ff[k]  <= rem_stg[k];
            root_ff[k] <= root_stg[k] >> 1;
         end
         pay_ff[k] <= pay_stg[k];
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1][15:0];
   assign out_pay   = pay_ff[N-1];
endmodule
`default_nettype wire

### src/qte_cordic.sv
`default_nettype none
module qte_cordic (
   input  wire logic                          clock,
   input  wire logic signed [qte_pkg::CW-1:0] in_y,
   input  wire logic signed [qte_pkg::CW-1:0] in_x,
   output logic signed [qte_pkg::ZW-1:0]      out_angle
);
   localparam int N = qte_pkg::CORDIC_STAGES;

   logic signed [qte_pkg::CW-1:0] x_ff [N+1];
   logic signed [qte_pkg::CW-1:0] y_ff [N+1];
   logic signed [qte_pkg::ZW-1:0] z_ff [N+1];
   logic [N:0]                    done_ff;

   // setup: zero operand and quarter turn into the right half plane
   always_ff @(posedge clock) begin
      done_ff[0] <= 1'b0;
      x_ff[0]    <= in_x;
      y_ff[0]    <= in_y;
      z_ff[0]    <= '0;
      if (in_y == '0) begin
         done_ff[0] <= 1'b1;
         z_ff[0]    <= in_x[qte_pkg::CW-1] ? qte_pkg::PI_Q20 : '0;
      end else if (in_x[qte_pkg::CW-1]) begin
         if (!in_y[qte_pkg::CW-1]) begin
            x_ff[0] <= in_y;
            y_ff[0] <= -in_x;
            z_ff[0] <= qte_pkg::HALF_PI_Q20;
         end else begin
            x_ff[0] <= -in_y;
            y_ff[0] <= in_x;
            z_ff[0] <= -qte_pkg::HALF_PI_Q20;
         end
      end
   end

   // vectoring micro-rotations
   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         done_ff[i+1] <= done_ff[i];
         if (done_ff[i]) begin
            x_ff[i+1] <= x_ff[i];
            y_ff[i+1] <= y_ff[i];
            z_ff[i+1] <= z_ff[i];
         end else if (!y_ff[i][qte_pkg::CW-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + qte_pkg::ATAN_Q20[i];
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - qte_pkg::ATAN_Q20[i];
         end
      end
   end

   // clamp to plus or minus pi
   always_comb begin
      if (z_ff[N] > qte_pkg::PI_Q20)
         out_angle = qte_pkg::PI_Q20;
      else if (z_ff[N] < -qte_pkg::PI_Q20)
         out_angle = -qte_pkg::PI_Q20;
      else
         out_angle = z_ff[N];
   end
endmodule
`default_nettype wire

### src/quaternion_to_euler_angles.sv
`default_nettype none
// Quaternion to gravity vector and roll, pitch, yaw.
// Request channel: drive req_quat_w/x/y/z (signed Q2.14) with start high;
// the request is taken at any clock edge where start is high and busy is
// low. busy never rises, so a new request may be given in every cycle.
// Response channel: rsp_valid is high for exactly one cycle per request
// and carries gravity (Q2.14, saturated) and the three angles in radians
// (Q3.13). Responses come out in request order and cannot be held off.
// From the accepting edge to the response the request passes the front
// end (products, gravity, squares, sum of squares), sixteen stages of
// the square root (one root bit each), the angle units (set-up plus
// sixteen micro-rotations, three units side by side) and one output
// register. Throughput is one request per cycle.
// Synchronous reset clears every valid flag so no response appears for
// requests taken before reset; data registers are not cleared.
module quaternion_to_euler_angles (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_grav_x,
   output logic signed [15:0]      rsp_grav_y,
   output logic signed [15:0]      rsp_grav_z,
   output logic signed [15:0]      rsp_roll_angle,
   output logic signed [15:0]      rsp_pitch_angle,
   output logic signed [15:0]      rsp_yaw_angle
);
   localparam int CL = qte_pkg::CORDIC_STAGES + 1;

   logic                 front_valid, sqrt_valid;
   logic [31:0]          front_sum;
   qte_pkg::payload_type front_pay, sqrt_pay;
   logic [15:0]          sqrt_root;
   logic signed [qte_pkg::ZW-1:0] roll_z, pitch_z, yaw_z, pitch_fold;
   logic [CL-1:0]        valid_ff;
   logic signed [15:0]   gx_ff [CL], gy_ff [CL], gz_ff [CL];
   logic                 valid_out_ff;
   logic signed [15:0]   gx_out_ff, gy_out_ff, gz_out_ff;
   logic signed [15:0]   roll_out_ff, pitch_out_ff, yaw_out_ff;

   // clamp a Q20 angle to plus or minus pi and round it half up to Q3.13
   function automatic logic signed [15:0] to_q13(input logic signed [qte_pkg::ZW-1:0] a);
      logic signed [qte_pkg::ZW-1:0] c;
      logic signed [qte_pkg::ZW-1:0] r;
      if (a > qte_pkg::PI_Q20)
         c = qte_pkg::PI_Q20;
      else if (a < -qte_pkg::PI_Q20)
         c = -qte_pkg::PI_Q20;
      else
         c = a;
      r = (c + 24'sd64) >>> 7;
      return r[15:0];
   endfunction

   assign busy = 1'b0;

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .out_valid (front_valid),
      .out_sum   (front_sum),
      .out_pay   (front_pay)
   );

   qte_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_sum    (front_sum),
      .in_pay    (front_pay),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_pay   (sqrt_pay)
   );

   // three angle units in lockstep
   qte_cordic u_roll (
      .clock     (clock),
      .in_y      (qte_pkg::CW'(sqrt_pay.gy) <<< 14),
      .in_x      (qte_pkg::CW'(sqrt_pay.gz) <<< 14),
      .out_angle (roll_z)
   );

   qte_cordic u_pitch (
      .clock     (clock),
      .in_y      (qte_pkg::CW'(sqrt_pay.gx) <<< 14),
      .in_x      ($signed({20'd0, sqrt_root}) <<< 14),
      .out_angle (pitch_z)
   );

   qte_cordic u_yaw (
      .clock     (clock),
      .in_y      (sqrt_pay.ya),
      .in_x      (sqrt_pay.yb),
      .out_angle (yaw_z)
   );

   // gravity and valid delayed alongside the angle units
   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= {valid_ff[CL-2:0], sqrt_valid};
   end

   always_ff @(posedge clock) begin
      gx_ff[0] <= sqrt_pay.gx;
      gy_ff[0] <= sqrt_pay.gy;
      gz_ff[0] <= sqrt_pay.gz;
      for (int k = 1; k < CL; k++) begin
         gx_ff[k] <= gx_ff[k-1];
         gy_ff[k] <= gy_ff[k-1];
         gz_ff[k] <= gz_ff[k-1];
      end
   end

   // pitch fold when gravity z points down
   always_comb begin
      if (gz_ff[CL-1] < 0) begin
         if (pitch_z > 0)
            pitch_fold = qte_pkg::PI_Q20 - pitch_z;
         else
            pitch_fold = -qte_pkg::PI_Q20 - pitch_z;
      end else begin
         pitch_fold = pitch_z;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset)
         valid_out_ff <= 1'b0;
      else
         valid_out_ff <= valid_ff[CL-1];
   end

   always_ff @(posedge clock) begin
      gx_out_ff    <= gx_ff[CL-1];
      gy_out_ff    <= gy_ff[CL-1];
      gz_out_ff    <= gz_ff[CL-1];
      roll_out_ff  <= to_q13(roll_z);
      pitch_out_ff <= to_q13(pitch_fold);
      yaw_out_ff   <= to_q13(yaw_z);
   end

   assign rsp_valid       = valid_out_ff;
   assign rsp_grav_x      = gx_out_ff;
   assign rsp_grav_y      = gy_out_ff;
   assign rsp_grav_z      = gz_out_ff;
   assign rsp_roll_angle  = roll_out_ff;
   assign rsp_pitch_angle = pitch_out_ff;
   assign rsp_yaw_angle   = yaw_out_ff;
endmodule
`default_nettype wire

### tb/qte_checker.sv
module qte_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic               rsp_valid,
   input  wire logic signed [15:0] rsp_grav_x,
   input  wire logic signed [15:0] rsp_grav_y,
   input  wire logic signed [15:0] rsp_grav_z,
   input  wire logic signed [15:0] rsp_roll_angle,
   input  wire logic signed [15:0] rsp_pitch_angle,
   input  wire logic signed [15:0] rsp_yaw_angle,
   output int                      fail_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import qte_pkg::*;

   typedef struct packed {
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic signed [15:0] gz;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } attitude_t;

   attitude_t attitude_q[$];

   // floor shift of a signed value
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // bitwise integer square root
   function automatic longint int_sqrt(longint n);
      longint root, bitv;
      root = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >>> 1) + bitv;
         end else begin
            root = root >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return root;
   endfunction

   // vectoring cordic atan2, angle in Q20
   function automatic longint angle_of(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (y == 0) return (x < 0) ? longint'(PI_Q20) : 0;
      if (x < 0) begin
         t = x;
         if (y > 0) begin
            x = y; y = -t; z = HALF_PI_Q20;
         end else begin
            x = -y; y = t; z = -longint'(HALF_PI_Q20);
         end
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_Q20[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_Q20[i];
         end
      end
      if (z > PI_Q20) z = PI_Q20;
      if (z < -longint'(PI_Q20)) z = -longint'(PI_Q20);
      return z;
   endfunction

   function automatic logic signed [15:0] rad_q13(longint a);
      if (a > PI_Q20) a = PI_Q20;
      if (a < -longint'(PI_Q20)) a = -longint'(PI_Q20);
      return 16'(fshift(a + 64, 7));
   endfunction

   // gravity and euler angles for one quaternion
   function automatic attitude_t predict_attitude(longint w, longint x, longint y,
                                                  longint z);
      attitude_t r;
      longint gx, gy, gz, mag, roll, pitch, ya, yb, yaw;
      gx = clamp16(fshift(2 * (x * z - w * y) + 8192, 14));
      gy = clamp16(fshift(2 * (w * x + y * z) + 8192, 14));
      gz = clamp16(fshift(w * w - x * x - y * y + z * z + 8192, 14));
      mag = int_sqrt(gy * gy + gz * gz);
      roll = angle_of(gy * 16384, gz * 16384);
      pitch = angle_of(gx * 16384, mag * 16384);
      ya = 2 * x * y - 2 * w * z;
      yb = 2 * w * w + 2 * x * x - (64'sd1 <<< 28);
      yaw = angle_of(ya, yb);
      if (gz < 0) begin
         if (pitch > 0) pitch = PI_Q20 - pitch;
         else pitch = -longint'(PI_Q20) - pitch;
      end
      r.gx = 16'(gx);
      r.gy = 16'(gy);
      r.gz = 16'(gz);
      r.roll = rad_q13(roll);
      r.pitch = rad_q13(pitch);
      r.yaw = rad_q13(yaw);
      return r;
   endfunction

   assign pending_count = attitude_q.size();

   // watch both channels
   always @(posedge clock) begin
      attitude_t got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy)
            attitude_q.push_back(predict_attitude(req_quat_w, req_quat_x,
                                                  req_quat_y, req_quat_z));
         if (rsp_valid) begin
            got = '{rsp_grav_x, rsp_grav_y, rsp_grav_z, rsp_roll_angle,
                    rsp_pitch_angle, rsp_yaw_angle};
            if (attitude_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = attitude_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/tb_quaternion_to_euler_angles.sv
module tb_quaternion_to_euler_angles;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 38;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic rsp_valid;
   logic signed [15:0] rsp_grav_x, rsp_grav_y, rsp_grav_z;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   int fail_count, pending_count;
   int idle_cycles = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   quaternion_to_euler_angles dut (.*);
   qte_checker checker_i (.*);

   // watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_quaternion_to_euler_angles: errors");
         $finish;
      end
   end

   // present one request and wait for acceptance
   task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z);
      start <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(int n);
      start <= 0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_part(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 32768) - 16384);
         2: return 16'($urandom_range(0, 1200) - 600);
         default: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      endcase
   endfunction

   initial begin
      logic [15:0] e [6] = '{16'h0000, 16'h4000, 16'hc000, 16'h7fff, 16'h8000, 16'h0001};
      int mode;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: identity, axes, extremes, gravity z negative, zero yaw operand
      send_quat(16'h4000, 0, 0, 0);
      send_quat(0, 16'h4000, 0, 0);
      send_quat(0, 0, 16'h4000, 0);
      send_quat(0, 0, 0, 16'h4000);
      send_quat(16'hc000, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_quat(16'h2d41, 16'h2d41, 0, 0);
      send_quat(16'h2d41, 0, 16'h2d41, 0);
      send_quat(16'h2d41, 0, 16'hd2bf, 0);
      send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
      send_quat(16'h1000, 16'h3000, 16'h2000, 16'h1000);
      send_quat(16'h1000, 16'hd000, 16'h2000, 16'h1000);
      send_quat(0, 16'h2d41, 16'h2d41, 0);
      for (int i = 0; i < 8; i++)
         send_quat(e[$urandom_range(0, 5)], e[$urandom_range(0, 5)],
                   e[$urandom_range(0, 5)], e[$urandom_range(0, 5)]);

      // hold off until the pipeline has drained
      start <= 0;
      while (pending_count != 0) @(posedge clock);

      // random requests, bursty idling except in the last part
      for (int n = 0; n < 1250; n++) begin
         if (n < 1000 && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 7));
         mode = $urandom_range(0, 9);
         mode = (mode < 3) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
         send_quat(rand_part(mode), rand_part(mode), rand_part(mode), rand_part(mode));
      end
      start <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("tb_quaternion_to_euler_angles: clean");
      else
         $display("tb_quaternion_to_euler_angles: errors");
      $finish;
   end
endmodule
